>>> rtl/core/lcr_pkg.sv
// Shared constants, types and helpers for the low-pass cubic resampler.
package lcr_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int PHASE_W    = FRAC_BITS + 5;
   localparam int SAMPLE_W   = 16;
   localparam int STEP_REG_W = 21;
   localparam int ALPHA_W    = 16;
   localparam int FILT_W     = 32;
   localparam int DIFF_W     = 34;
   localparam int COEF_W     = 21;
   localparam int MUL_A_W    = 21;
   localparam int MUL_B_W    = 34;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_Y_W    = 24;
   localparam int CNT_W      = 4;
   localparam int PRIME_W    = 3;
   localparam int CSR_IDX_W  = 2;

   localparam logic [PHASE_W-1:0]    PHASE_ONE  = PHASE_W'(1) << FRAC_BITS;
   localparam logic [PHASE_W-1:0]    STEP_MIN   = PHASE_ONE >> 3;
   localparam logic [PHASE_W-1:0]    STEP_MAX   = PHASE_ONE << 4;
   localparam logic [STEP_REG_W-1:0] STEP_RESET = STEP_REG_W'(65536);
   localparam logic [ALPHA_W-1:0]    ALPHA_MAX  = ALPHA_W'(32768);
   localparam logic [CNT_W-1:0]      MAX_OUT    = CNT_W'(8);
   localparam logic [PRIME_W-1:0]    PRIME_DONE = PRIME_W'(4);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP  = 2'd0,
      CSR_ALPHA = 2'd1,
      CSR_PASS  = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PASS,
      S_FILT,
      S_FADD,
      S_WIN,
      S_COEF,
      S_CHECK,
      S_T2,
      S_T3,
      S_P1,
      S_P2,
      S_P3,
      S_FIN
   } state_type;

   typedef enum logic [2:0] {
      MUL_FILT,
      MUL_TT,
      MUL_T2T,
      MUL_C1,
      MUL_C2,
      MUL_C3
   } mul_sel_type;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [DIFF_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v < -DIFF_W'(32768)) begin
         r = -16'sd32768;
      end else if (v > DIFF_W'(32767)) begin
         r = 16'sd32767;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/lowpass_cubic_resampler_top.sv
// Low-pass filtered Catmull-Rom cubic resampler built around one shared multiplier.
// Pass-through: the input word is registered, then copied to the result register once the
// output is free; no new input word is taken until the sequencer is back in idle.
// Resampling: each word is filtered and shifted into the window and, once priming is done,
// gives up to eight results; a stalled result word holds the sequencer. Synchronous
// active-high reset clears filter, taps, phase, priming and result counts, output valid.
module lowpass_cubic_resampler_top
   import lcr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SAMPLE_W-1:0]   req_in_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]   rsp_out_sample,
   output logic                         rsp_last_of_run,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [STEP_REG_W-1:0]        csr_data
);

   state_type state_ff, state_in;
   mul_sel_type mul_sel;

   logic [STEP_REG_W-1:0] step_ff, step_in;
   logic [ALPHA_W-1:0]    alpha_ff, alpha_in;
   logic                  pass_ff, pass_in;

   logic signed [FILT_W-1:0]   facc_ff, facc_in;
   logic signed [SAMPLE_W-1:0] win_ff [4];
   logic signed [SAMPLE_W-1:0] win_in [4];
   logic [PRIME_W-1:0]         prime_ff, prime_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] filt_ff, filt_in;
   logic signed [COEF_W-1:0]   c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic [FRAC_BITS-1:0]       t2_ff, t2_in, t3_ff, t3_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_Y_W-1:0]  accy_ff, accy_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       in_take, out_free, out_load, mul_on;
   logic [ALPHA_W-1:0]         alpha_used;
   logic                       alpha_zero;
   logic [PHASE_W-1:0]         step_used, phase_next;
   logic [FRAC_BITS-1:0]       t_val;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [DIFF_W-1:0]   fdiff, fsum;
   logic signed [ACC_Y_W-1:0]  prod_frac, y_fin;
   logic signed [COEF_W-1:0]   e_sm1, e_s0, e_s1, e_s2;

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_sample  = rsp_sample_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // Clamped controls.
   assign alpha_used = (alpha_ff > ALPHA_MAX) ? ALPHA_MAX : alpha_ff;
   assign alpha_zero = (alpha_used == '0);
   always_comb begin
      if (step_ff < STEP_REG_W'(STEP_MIN)) begin
         step_used = STEP_MIN;
      end else if (step_ff > STEP_REG_W'(STEP_MAX)) begin
         step_used = STEP_MAX;
      end else begin
         step_used = step_ff[PHASE_W-1:0];
      end
   end

   assign t_val      = phase_ff[FRAC_BITS-1:0];
   assign phase_next = phase_ff + step_used;
   assign fdiff      = (DIFF_W'(x_ff) <<< 15) - DIFF_W'(facc_ff);
   assign fsum       = DIFF_W'(facc_ff) + DIFF_W'(prod_ff >>> 15);
   assign prod_frac  = ACC_Y_W'(prod_ff >>> FRAC_BITS);
   assign y_fin      = accy_ff + prod_frac;

   assign e_sm1 = COEF_W'(win_ff[0]);
   assign e_s0  = COEF_W'(win_ff[1]);
   assign e_s1  = COEF_W'(win_ff[2]);
   assign e_s2  = COEF_W'(win_ff[3]);

   // Control outputs of the sequencer.
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      in_take   = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
      out_load  = ((state_ff == S_PASS) || (state_ff == S_FIN)) && out_free;
      mul_on    = 1'b1;
      case (state_ff)
         S_FILT:  mul_sel = MUL_FILT;
         S_T2:    mul_sel = MUL_TT;
         S_T3:    mul_sel = MUL_T2T;
         S_P1:    mul_sel = MUL_C1;
         S_P2:    mul_sel = MUL_C2;
         S_P3:    mul_sel = MUL_C3;
         default: begin
            mul_sel = MUL_FILT;
            mul_on  = 1'b0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_take) begin
               state_in = pass_ff ? S_PASS : S_FILT;
            end
         end
         S_PASS: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_FILT:  state_in = alpha_zero ? S_WIN : S_FADD;
         S_FADD:  state_in = S_WIN;
         S_WIN: begin
            if ((prime_ff < PRIME_DONE) && (prime_ff + PRIME_W'(1) < PRIME_DONE)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_COEF;
            end
         end
         S_COEF:  state_in = S_CHECK;
         S_CHECK: begin
            if ((phase_ff < PHASE_ONE) && (cnt_ff != MAX_OUT)) begin
               state_in = S_T2;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_T2:    state_in = S_T3;
         S_T3:    state_in = S_P1;
         S_P1:    state_in = S_P2;
         S_P2:    state_in = S_P3;
         S_P3:    state_in = S_FIN;
         S_FIN: begin
            if (out_free) begin
               state_in = S_CHECK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Shared multiplier operand select.
   always_comb begin
      case (mul_sel)
         MUL_FILT: begin
            mul_a = MUL_A_W'({1'b0, alpha_used});
            mul_b = fdiff;
         end
         MUL_TT: begin
            mul_a = MUL_A_W'({1'b0, t_val});
            mul_b = MUL_B_W'({1'b0, t_val});
         end
         MUL_T2T: begin
            mul_a = MUL_A_W'({1'b0, FRAC_BITS'(prod_ff >>> FRAC_BITS)});
            mul_b = MUL_B_W'({1'b0, t_val});
         end
         MUL_C1: begin
            mul_a = c1_ff;
            mul_b = MUL_B_W'({1'b0, t_val});
         end
         MUL_C2: begin
            mul_a = c2_ff;
            mul_b = MUL_B_W'({1'b0, t2_ff});
         end
         MUL_C3: begin
            mul_a = c3_ff;
            mul_b = MUL_B_W'({1'b0, t3_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      step_in       = step_ff;
      alpha_in      = alpha_ff;
      pass_in       = pass_ff;
      facc_in       = facc_ff;
      win_in        = win_ff;
      prime_in      = prime_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      filt_in       = filt_ff;
      c1_in         = c1_ff;
      c2_in         = c2_ff;
      c3_in         = c3_ff;
      t2_in         = t2_ff;
      t3_in         = t3_ff;
      accy_in       = accy_ff;
      prod_in       = mul_on ? (mul_a * mul_b) : prod_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP:  step_in  = csr_data;
            CSR_ALPHA: alpha_in = csr_data[ALPHA_W-1:0];
            CSR_PASS:  pass_in  = csr_data[0];
            default:   ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (in_take) begin
               x_in = req_in_sample;
            end
         end
         S_PASS: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = x_ff;
               rsp_last_in   = 1'b1;
            end
         end
         S_FILT: begin
            if (alpha_zero) begin
               filt_in = x_ff;
            end
         end
         S_FADD: begin
            facc_in = fsum[FILT_W-1:0];
            filt_in = sat16(fsum >>> 15);
         end
         S_WIN: begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = win_ff[3];
            win_in[3] = filt_ff;
            cnt_in    = '0;
            if (prime_ff < PRIME_DONE) begin
               prime_in = prime_ff + PRIME_W'(1);
               phase_in = step_used;
            end else begin
               phase_in = (phase_ff >= PHASE_ONE) ? (phase_ff - PHASE_ONE) : '0;
            end
         end
         S_COEF: begin
            c1_in = e_s1 - e_sm1;
            c2_in = (e_sm1 <<< 1) - (e_s0 <<< 2) - e_s0 + (e_s1 <<< 2) - e_s2;
            c3_in = e_s2 - e_sm1 + (e_s0 <<< 1) + e_s0 - (e_s1 <<< 1) - e_s1;
         end
         S_T3: t2_in = FRAC_BITS'(prod_ff >>> FRAC_BITS);
         S_P1: t3_in = FRAC_BITS'(prod_ff >>> FRAC_BITS);
         S_P2: accy_in = (ACC_Y_W'(win_ff[1]) <<< 1) + prod_frac;
         S_P3: accy_in = accy_ff + prod_frac;
         S_FIN: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sat16(DIFF_W'(y_fin >>> 1));
               rsp_last_in   = (phase_next >= PHASE_ONE) || (cnt_ff == MAX_OUT - CNT_W'(1));
               phase_in      = phase_next;
               cnt_in        = cnt_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= STEP_RESET;
         alpha_ff     <= '0;
         pass_ff      <= 1'b0;
         facc_ff      <= '0;
         win_ff       <= '{default: '0};
         prime_ff     <= '0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         alpha_ff     <= alpha_in;
         pass_ff      <= pass_in;
         facc_ff      <= facc_in;
         win_ff       <= win_in;
         prime_ff     <= prime_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      filt_ff       <= filt_in;
      c1_ff         <= c1_in;
      c2_ff         <= c2_in;
      c3_ff         <= c3_in;
      t2_ff         <= t2_in;
      t3_ff         <= t3_in;
      prod_ff       <= prod_in;
      accy_ff       <= accy_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // A new result word appears only from the pass-through or final interpolation step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_PASS || $past(state_ff) == S_FIN))
      else $error("result word loaded outside an output step");

   // An accepted input word always starts the sequencer.
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_PASS || state_ff == S_FILT))
      else $error("accepted word did not start processing");

   // No more than eight results per input word.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_OUT)
      else $error("result count overran");

   // Interpolation only starts with the phase inside one sample interval.
   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_T2) |-> (phase_ff < PHASE_ONE))
      else $error("interpolation started with phase out of range");

   // Priming count saturates at four.
   a_prime_bound: assert property (@(posedge clock) disable iff (reset)
      prime_ff <= PRIME_DONE)
      else $error("priming count overran");

endmodule
